>>> rtl/uniform_grid_neighbor_query_top_macros.svh
// Assertion macros shared by the grid neighbour query RTL.
`ifndef UNIFORM_GRID_NEIGHBOR_QUERY_TOP_MACROS_SVH
`define UNIFORM_GRID_NEIGHBOR_QUERY_TOP_MACROS_SVH

// Checked on every rising edge of clk, switched off while arst_n is low.
`define UGNQ_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The same with a general message.
`define UGNQ_ASSERT(lbl, prop) \
	`UGNQ_ASSERT_MSG(lbl, prop, "grid neighbour query check failed")

`endif

>>> rtl/ugnq_pkg.sv
package ugnq_pkg;

	localparam int GRID_ROWS  = 8;
	localparam int GRID_COLS  = 8;
	localparam int MAX_AGENTS = 64;
	localparam int NUM_CELLS  = GRID_ROWS * GRID_COLS;
	localparam int CELL_LIMIT = (NUM_CELLS < 64) ? NUM_CELLS : 64;
	localparam int AW         = $clog2(MAX_AGENTS);

	localparam logic [6:0] NO_CELL = 7'd64;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_MOVE  = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	localparam logic REG_CELL_W = 1'b0;
	localparam logic REG_CELL_H = 1'b1;

	typedef logic signed [31:0] coord_t;
	typedef logic [5:0] axis_idx_t;

	typedef struct packed {
		logic      start;
		axis_idx_t last_idx;
		logic [22:0] size;
		coord_t    lo;
		coord_t    hi;
	} scan_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] mask;
		axis_idx_t   first;
		logic        hit;
	} scan_rsp_t;

	typedef struct packed {
		logic [AW-1:0]      rd_addr;
		logic               we_pos;
		logic               we_cell;
		logic [AW-1:0]      waddr;
		logic               clr;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic [6:0]         cell_no;
		logic [31:0]        ord;
	} store_req_t;

	typedef struct packed {
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic [6:0]         cell_no;
		logic [31:0]        ord;
	} store_rsp_t;

	function automatic axis_idx_t cell_col(input logic [6:0] c);
		return axis_idx_t'(c % GRID_COLS);
	endfunction

	function automatic axis_idx_t cell_row(input logic [6:0] c);
		return axis_idx_t'(c / GRID_COLS);
	endfunction

endpackage

>>> rtl/ugnq_scan.sv
module ugnq_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  ugnq_pkg::scan_req_t req,
	output ugnq_pkg::scan_rsp_t rsp
);
	import ugnq_pkg::*;

	logic        busy_q;
	logic        done_q;
	axis_idx_t   k_q;
	axis_idx_t   last_q;
	coord_t      l_q;
	coord_t      step_q;
	coord_t      lo_q;
	coord_t      hi_q;
	logic [63:0] mask_q;
	axis_idx_t   first_q;
	logic        hit_q;

	coord_t r_edge;
	logic   hit;
	coord_t count;

	assign count  = coord_t'({1'b0, req.last_idx}) + 32'sd1;
	assign r_edge = l_q + step_q;
	assign hit    = (l_q <= hi_q) && (r_edge >= lo_q);

	// Walks the cell edges along one axis, one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				hit_q  <= 1'b0;
			end else if (busy_q) begin
				if (hit && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (k_q == last_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			k_q     <= '0;
			last_q  <= req.last_idx;
			l_q     <= -(count * coord_t'({9'b0, req.size}));
			step_q  <= coord_t'({9'b0, req.size}) <<< 1;
			lo_q    <= req.lo;
			hi_q    <= req.hi;
			mask_q  <= '0;
			first_q <= '0;
		end else if (busy_q) begin
			mask_q[k_q] <= hit;
			if (hit && !hit_q) begin
				first_q <= k_q;
			end
			l_q <= r_edge;
			k_q <= k_q + 6'd1;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.mask  = mask_q;
	assign rsp.first = first_q;
	assign rsp.hit   = hit_q;

endmodule

>>> rtl/ugnq_store.sv
module ugnq_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ugnq_pkg::store_req_t req,
	output ugnq_pkg::store_rsp_t rsp
);
	import ugnq_pkg::*;

	logic signed [23:0] px_mem   [MAX_AGENTS];
	logic signed [23:0] py_mem   [MAX_AGENTS];
	logic [6:0]         cell_mem [MAX_AGENTS];
	logic [31:0]        ord_mem  [MAX_AGENTS];

	logic [MAX_AGENTS-1:0] valid_q;
	logic                  rd_vld_q;
	logic signed [23:0]    rd_px_q;
	logic signed [23:0]    rd_py_q;
	logic [6:0]            rd_cell_q;
	logic [31:0]           rd_ord_q;

	always_ff @(posedge clk) begin
		if (req.we_pos) begin
			px_mem[req.waddr] <= req.px;
			py_mem[req.waddr] <= req.py;
		end
		if (req.we_cell) begin
			cell_mem[req.waddr] <= req.cell_no;
			ord_mem[req.waddr]  <= req.ord;
		end
		rd_px_q   <= px_mem[req.rd_addr];
		rd_py_q   <= py_mem[req.rd_addr];
		rd_cell_q <= cell_mem[req.rd_addr];
		rd_ord_q  <= ord_mem[req.rd_addr];
	end

	// An agent whose cell was never written since the last clear has no cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[req.rd_addr];
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.we_cell) begin
				valid_q[req.waddr] <= 1'b1;
			end
		end
	end

	assign rsp.px      = rd_px_q;
	assign rsp.py      = rd_py_q;
	assign rsp.cell_no = rd_vld_q ? rd_cell_q : NO_CELL;
	assign rsp.ord     = rd_ord_q;

endmodule

>>> rtl/uniform_grid_neighbor_query_top.sv
// Uniform grid neighbour search over up to 64 agents on a grid of cells centred on
// the origin. An item is taken when start is high and busy is low; busy then stays
// high until the item's final result has been issued. Every item gives at least one
// result beat: result_valid is high for exactly one cycle per beat, and the final
// beat of an item has last set. There is no back-pressure on the result side, so
// whatever consumes the results must take each beat in the cycle it appears.
// Timing is set by one axis scanner that tests one cell edge per cycle and by the
// single read port of the agent store. A clear, or an ignored agent, gives its
// result directly, with no scan. An add runs two axis scans of 8 cells and then
// places the agent; a move scans for both the old and the new position. A
// neighbour query scans both axes and squares the radius, then takes each of the
// 64 stored agents through a store read, two squares through the shared
// multiplier and the range compare, then runs one selection sweep over the store
// per neighbour reported, as neighbours are picked one at a time in order of
// cell, then insertion order, then agent id. Cell sizes must be written through
// the APB port only while the block is idle; the block itself does not enforce
// it.
`include "uniform_grid_neighbor_query_top_macros.svh"

module uniform_grid_neighbor_query_top (
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// command side
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  logic [5:0]          agent_id,
	input  logic signed [23:0]  pos_x,
	input  logic signed [23:0]  pos_y,
	input  logic signed [23:0]  old_x,
	input  logic signed [23:0]  old_y,
	input  logic [22:0]         radius,
	// result side
	output logic                result_valid,
	output logic [5:0]          neighbor_id,
	output logic                found,
	output logic [6:0]          cell_index,
	output logic                last
);
	import ugnq_pkg::*;

	typedef enum logic [16:0] {
		ST_IDLE  = 17'b0_0000_0000_0000_0001,
		ST_SCANX = 17'b0_0000_0000_0000_0010,
		ST_SCANY = 17'b0_0000_0000_0000_0100,
		ST_CELL  = 17'b0_0000_0000_0000_1000,
		ST_PLACE = 17'b0_0000_0000_0001_0000,
		ST_MREAD = 17'b0_0000_0000_0010_0000,
		ST_MDONE = 17'b0_0000_0000_0100_0000,
		ST_R2    = 17'b0_0000_0000_1000_0000,
		ST_QRD   = 17'b0_0000_0001_0000_0000,
		ST_QDX   = 17'b0_0000_0010_0000_0000,
		ST_QDY   = 17'b0_0000_0100_0000_0000,
		ST_QCMP  = 17'b0_0000_1000_0000_0000,
		ST_ESCAN = 17'b0_0001_0000_0000_0000,
		ST_ETAIL = 17'b0_0010_0000_0000_0000,
		ST_EOUT  = 17'b0_0100_0000_0000_0000,
		ST_CLR   = 17'b0_1000_0000_0000_0000,
		ST_IGN   = 17'b1_0000_0000_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [22:0] cell_w_q;
	logic [22:0] cell_h_q;

	// The accepted item.
	mode_t              mode_q;
	logic [5:0]         id_q;
	logic signed [23:0] px_q;
	logic signed [23:0] py_q;
	logic signed [23:0] ox_q;
	logic signed [23:0] oy_q;
	logic [22:0]        rad_q;

	// Sequencer state.
	logic        scan_go_q;
	logic        pass_q;
	logic [63:0] colmask_q;
	logic [63:0] rowmask_q;
	axis_idx_t   col_q;
	axis_idx_t   row_q;
	logic        hitx_q;
	logic        hity_q;
	logic [6:0]  newc_q;
	logic [6:0]  oldc_q;
	logic [31:0] insert_q;

	// Query datapath.
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         idx_s1;
	logic                  v_s1;
	logic [MAX_AGENTS-1:0] match_q;
	logic [AW:0]           cnt_q;
	logic [49:0]           r2_q;
	logic signed [49:0]    prod_q;
	logic signed [49:0]    acc_q;
	logic                  best_v_q;
	logic [AW-1:0]         best_id_q;
	logic [6:0]            best_cell_q;
	logic [31:0]           best_ord_q;

	// Result registers.
	logic       res_v_q;
	logic [5:0] res_id_q;
	logic       res_found_q;
	logic [6:0] res_cell_q;
	logic       res_last_q;

	scan_req_t  sreq;
	scan_rsp_t  srsp;
	store_req_t mreq;
	store_rsp_t mrsp;

	ugnq_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rsp    (srsp)
	);

	ugnq_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// APB: always ready, bit 2 of the address picks the register.
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CELL_H) ? {9'b0, cell_h_q} : {9'b0, cell_w_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_w_q <= 23'd256;
			cell_h_q <= 23'd256;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_CELL_W) begin
				cell_w_q <= pwdata[22:0];
			end else begin
				cell_h_q <= pwdata[22:0];
			end
		end
	end

	// Axis scan request. A query tests the square around the point, add and move
	// test the point itself; the first pass of a move locates the old position.
	logic               on_x;
	logic               use_old;
	logic signed [23:0] pick;
	coord_t             pc;
	coord_t             rc;

	always_comb begin
		on_x    = (state_q == ST_SCANX);
		use_old = (mode_q == MODE_MOVE) && !pass_q;
		if (on_x) begin
			pick = use_old ? ox_q : px_q;
		end else begin
			pick = use_old ? oy_q : py_q;
		end
		pc = coord_t'(pick);
		rc = (mode_q == MODE_QUERY) ? coord_t'({9'b0, rad_q}) : '0;
		sreq.start    = scan_go_q;
		sreq.last_idx = on_x ? axis_idx_t'(GRID_COLS - 1) : axis_idx_t'(GRID_ROWS - 1);
		sreq.size     = on_x ? cell_w_q : cell_h_q;
		sreq.lo       = (pc - rc) <<< 1;
		sreq.hi       = (pc + rc) <<< 1;
	end

	// Cell of the point just located.
	logic [12:0] lin;
	logic [6:0]  pt_cell;
	assign lin     = 13'(row_q) * 13'(GRID_COLS) + 13'(col_q);
	assign pt_cell = (hitx_q && hity_q && (lin < 13'(CELL_LIMIT))) ? lin[6:0] : NO_CELL;

	// Move resolution, with the agent's present cell from the store.
	logic       mv_same;
	logic       mv_we;
	logic [6:0] mv_cell;
	always_comb begin
		mv_same = (oldc_q == newc_q);
		if (mv_same) begin
			mv_cell = mrsp.cell_no;
			mv_we   = 1'b0;
		end else if (newc_q != NO_CELL) begin
			mv_cell = newc_q;
			mv_we   = 1'b1;
		end else if (mrsp.cell_no == oldc_q) begin
			mv_cell = NO_CELL;
			mv_we   = 1'b1;
		end else begin
			mv_cell = mrsp.cell_no;
			mv_we   = 1'b0;
		end
	end

	// Store port.
	always_comb begin
		mreq.rd_addr = (state_q == ST_MREAD) ? id_q[AW-1:0] : idx_q;
		mreq.we_pos  = (state_q == ST_PLACE) || (state_q == ST_MDONE);
		mreq.we_cell = (state_q == ST_PLACE) || ((state_q == ST_MDONE) && mv_we);
		mreq.waddr   = id_q[AW-1:0];
		mreq.clr     = (state_q == ST_CLR);
		mreq.px      = px_q;
		mreq.py      = py_q;
		mreq.cell_no = (state_q == ST_PLACE) ? newc_q : mv_cell;
		mreq.ord     = insert_q;
	end

	// The one multiplier: radius squared once, then dx and dy squared per agent.
	logic signed [24:0] mul_a;
	logic signed [49:0] mul_p;
	always_comb begin
		case (state_q)
			ST_R2:   mul_a = $signed({2'b0, rad_q});
			ST_QDX:  mul_a = 25'(mrsp.px) - 25'(px_q);
			default: mul_a = 25'(mrsp.py) - 25'(py_q);
		endcase
		mul_p = mul_a * mul_a;
	end

	// Range and cell-overlap test for the agent at idx_q.
	logic [50:0] d2;
	logic        q_ok;
	assign d2   = {1'b0, acc_q} + {1'b0, prod_q};
	assign q_ok = (idx_q != id_q[AW-1:0]) && (mrsp.cell_no < 7'(CELL_LIMIT)) &&
		colmask_q[cell_col(mrsp.cell_no)] && rowmask_q[cell_row(mrsp.cell_no)] &&
		(d2 <= {1'b0, r2_q});

	// Selection of the next neighbour in output order.
	logic better;
	assign better = v_s1 && match_q[idx_s1] && (!best_v_q || (mrsp.cell_no < best_cell_q) ||
		((mrsp.cell_no == best_cell_q) && (mrsp.ord < best_ord_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_go_q   <= 1'b0;
			pass_q      <= 1'b0;
			insert_q    <= '0;
			res_v_q     <= 1'b0;
			match_q     <= '0;
			cnt_q       <= '0;
			best_v_q    <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			scan_go_q <= 1'b0;
			res_v_q   <= 1'b0;
			v_s1      <= (state_q == ST_ESCAN);
			if (better) begin
				best_v_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pass_q <= 1'b0;
						if (mode_t'(mode) == MODE_CLEAR) begin
							state_q <= ST_CLR;
						end else if ({1'b0, agent_id} >= 7'(MAX_AGENTS)) begin
							state_q <= ST_IGN;
						end else begin
							state_q   <= ST_SCANX;
							scan_go_q <= 1'b1;
						end
					end
				end
				ST_SCANX: begin
					if (srsp.done) begin
						state_q   <= ST_SCANY;
						scan_go_q <= 1'b1;
					end
				end
				ST_SCANY: begin
					if (srsp.done) begin
						state_q <= (mode_q == MODE_QUERY) ? ST_R2 : ST_CELL;
					end
				end
				ST_CELL: begin
					if (mode_q == MODE_ADD) begin
						state_q <= ST_PLACE;
					end else if (!pass_q) begin
						pass_q    <= 1'b1;
						state_q   <= ST_SCANX;
						scan_go_q <= 1'b1;
					end else begin
						state_q <= ST_MREAD;
					end
				end
				ST_PLACE: begin
					if (newc_q != NO_CELL) begin
						insert_q <= insert_q + 32'd1;
					end
					res_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_MREAD: begin
					state_q <= ST_MDONE;
				end
				ST_MDONE: begin
					if (!mv_same && (newc_q != NO_CELL)) begin
						insert_q <= insert_q + 32'd1;
					end
					res_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_R2: begin
					match_q <= '0;
					cnt_q   <= '0;
					state_q <= ST_QRD;
				end
				ST_QRD: begin
					state_q <= ST_QDX;
				end
				ST_QDX: begin
					state_q <= ST_QDY;
				end
				ST_QDY: begin
					state_q <= ST_QCMP;
				end
				ST_QCMP: begin
					if (q_ok) begin
						match_q[idx_q] <= 1'b1;
						cnt_q          <= cnt_q + 1'b1;
					end
					if (idx_q == AW'(MAX_AGENTS - 1)) begin
						if ((cnt_q == '0) && !q_ok) begin
							res_v_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							best_v_q <= 1'b0;
							state_q  <= ST_ESCAN;
						end
					end else begin
						state_q <= ST_QRD;
					end
				end
				ST_ESCAN: begin
					if (idx_q == AW'(MAX_AGENTS - 1)) begin
						state_q <= ST_ETAIL;
					end
				end
				ST_ETAIL: begin
					state_q <= ST_EOUT;
				end
				ST_EOUT: begin
					match_q[best_id_q] <= 1'b0;
					cnt_q              <= cnt_q - 1'b1;
					res_v_q            <= 1'b1;
					best_v_q           <= 1'b0;
					state_q            <= (cnt_q == (AW+1)'(1)) ? ST_IDLE : ST_ESCAN;
				end
				ST_CLR: begin
					res_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_IGN: begin
					res_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			id_q   <= agent_id;
			px_q   <= pos_x;
			py_q   <= pos_y;
			ox_q   <= old_x;
			oy_q   <= old_y;
			rad_q  <= radius;
		end
		if (srsp.done && (state_q == ST_SCANX)) begin
			colmask_q <= srsp.mask;
			col_q     <= srsp.first;
			hitx_q    <= srsp.hit;
		end
		if (srsp.done && (state_q == ST_SCANY)) begin
			rowmask_q <= srsp.mask;
			row_q     <= srsp.first;
			hity_q    <= srsp.hit;
		end
		if (state_q == ST_CELL) begin
			newc_q <= pt_cell;
			if (!pass_q) begin
				oldc_q <= pt_cell;
			end
		end
		if (state_q == ST_R2) begin
			r2_q <= 50'(mul_p);
		end
		if ((state_q == ST_QDX) || (state_q == ST_QDY)) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_QDY) begin
			acc_q <= prod_q;
		end
		case (state_q)
			ST_R2:    idx_q <= '0;
			ST_QCMP:  idx_q <= idx_q + 1'b1;
			ST_ESCAN: idx_q <= idx_q + 1'b1;
			default:  idx_q <= idx_q;
		endcase
		idx_s1 <= idx_q;
		if (better) begin
			best_id_q   <= idx_s1;
			best_cell_q <= mrsp.cell_no;
			best_ord_q  <= mrsp.ord;
		end

		// Result beat contents.
		res_id_q    <= '0;
		res_found_q <= 1'b0;
		res_last_q  <= 1'b1;
		case (state_q)
			ST_PLACE: res_cell_q <= newc_q;
			ST_MDONE: res_cell_q <= mv_cell;
			ST_QCMP:  res_cell_q <= 7'd0;
			ST_EOUT: begin
				res_id_q    <= 6'(best_id_q);
				res_found_q <= 1'b1;
				res_cell_q  <= best_cell_q;
				res_last_q  <= (cnt_q == (AW+1)'(1));
			end
			default:  res_cell_q <= NO_CELL;
		endcase
	end

	assign result_valid = res_v_q;
	assign neighbor_id  = res_id_q;
	assign found        = res_found_q;
	assign cell_index   = res_cell_q;
	assign last         = res_last_q;

	`UGNQ_ASSERT(a_accept_goes_busy, start && !busy |=> busy)
	`UGNQ_ASSERT_MSG(a_empty_beat_is_last, result_valid && !found |-> last, "empty beat not last")
	`UGNQ_ASSERT(a_found_in_grid, result_valid && found |-> (cell_index < 7'(CELL_LIMIT)))
	`UGNQ_ASSERT(a_emit_has_pick, (state_q == ST_EOUT) |-> best_v_q && (cnt_q != '0))

endmodule
